// File: rtl/segmented_fifo_page_replacer_assert.svh
// assertion macros for the segmented fifo page replacer
`ifndef SEGMENTED_FIFO_PAGE_REPLACER_ASSERT_SVH
`define SEGMENTED_FIFO_PAGE_REPLACER_ASSERT_SVH

// same-cycle implication
`define SFPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sfpr_pkg.sv
// shared types and constants of the segmented fifo page replacer
package sfpr_pkg;

  localparam int ADDR_W     = 32;
  localparam int EVP_W      = 20;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int PROD_W     = 14;
  localparam int MUL_W      = 27;
  localparam int DIV_SHIFT  = 19;

  localparam logic [12:0] DIV_MUL = 13'd5243;
  localparam logic [6:0]  PCT_MAX = 7'd100;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LRU_PERCENT  = 2'd1;

  localparam logic [CFG_DATA_W-1:0] TOTAL_RESET = 7'd64;
  localparam logic [CFG_DATA_W-1:0] PCT_RESET   = 7'd25;

  localparam logic [1:0] KIND_HIT   = 2'd0;
  localparam logic [1:0] KIND_SOFT  = 2'd1;
  localparam logic [1:0] KIND_FAULT = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              is_write;
  } in_t;

  typedef struct packed {
    logic [1:0]       access_kind;
    logic             disk_read;
    logic             disk_write;
    logic             evicted_valid;
    logic [EVP_W-1:0] evicted_page;
    logic [CNT_W-1:0] read_count;
    logic [CNT_W-1:0] write_count;
    logic [CNT_W-1:0] access_count;
  } out_t;

endpackage

// File: rtl/sfpr_ram.sv
// generic single-write single-read ram with registered read
module sfpr_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/segmented_fifo_page_replacer.sv
// segmented fifo page replacer top level
// sequence: product and divide setup, a search over the resident pages of each segment, a
// shift of the lru entries on a hit, a tail read and a fifo pop where needed, then a finish
// step; one access at a time, a new start is taken only while idle, and the pace is set
// by the single read port of each segment ram
// synchronous active-low reset empties both segments, clears counters, loads 64 / 25
module segmented_fifo_page_replacer #(
  parameter int MAX_FRAMES = 64,
  parameter int PAGE_SHIFT = 12,
  parameter int PAGE_BITS  = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  sfpr_pkg::in_t                       in_data,
  output logic                                out_valid,
  output sfpr_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfpr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sfpr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int SW = CW + 1;
  localparam int EW = PAGE_BITS + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PROD  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_FSRCH = 4'd3;
  localparam logic [3:0] S_LSRCH = 4'd4;
  localparam logic [3:0] S_SHIFT = 4'd5;
  localparam logic [3:0] S_TAIL0 = 4'd6;
  localparam logic [3:0] S_TAIL1 = 4'd7;
  localparam logic [3:0] S_POP0  = 4'd8;
  localparam logic [3:0] S_POP1  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  localparam logic [2:0] M_LHIT  = 3'd0;
  localparam logic [2:0] M_SOFT  = 3'd1;
  localparam logic [2:0] M_LMISS = 3'd2;
  localparam logic [2:0] M_FMISS = 3'd3;
  localparam logic [2:0] M_MMISS = 3'd4;

  function automatic logic [FW-1:0] phys(input logic [FW-1:0] h, input logic [CW-1:0] i);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(i);
    if (s >= SW'(MAX_FRAMES)) begin
      s = s - SW'(MAX_FRAMES);
    end
    return s[FW-1:0];
  endfunction

  function automatic logic [FW-1:0] inc_slot(input logic [FW-1:0] h);
    return (SW'(h) == SW'(MAX_FRAMES - 1)) ? '0 : FW'(SW'(h) + SW'(1));
  endfunction

  function automatic logic [FW-1:0] dec_slot(input logic [FW-1:0] h);
    return (h == '0) ? FW'(MAX_FRAMES - 1) : FW'(SW'(h) - SW'(1));
  endfunction

  logic [3:0]                     state_r, state_nxt;
  logic [2:0]                     mode_r, mode_nxt;
  logic [sfpr_pkg::CFG_DATA_W-1:0] tot_cfg_r, tot_cfg_nxt, pct_cfg_r, pct_cfg_nxt;
  logic [PAGE_BITS-1:0]           page_r, page_nxt;
  logic                           wr_r, wr_nxt;
  logic [sfpr_pkg::PROD_W-1:0]    prod_r, prod_nxt;
  logic [CW-1:0]                  tot_r, tot_nxt, lenl_r, lenl_nxt;
  logic [FW-1:0]                  fhead_r, fhead_nxt, lhead_r, lhead_nxt;
  logic [CW-1:0]                  fused_r, fused_nxt, lused_r, lused_nxt;
  logic [sfpr_pkg::CNT_W-1:0]     reads_r, reads_nxt, writes_r, writes_nxt, acc_r, acc_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt, cidx_r, cidx_nxt;
  logic                           cv_r, cv_nxt;
  logic                           hitd_r, hitd_nxt, pop_r, pop_nxt;
  logic [PAGE_BITS-1:0]           pop_pg_r, pop_pg_nxt, evp_r, evp_nxt;
  logic                           pop_d_r, pop_d_nxt;
  logic [1:0]                     kind_r, kind_nxt;
  logic                           dw_r, dw_nxt, evv_r, evv_nxt;
  logic                           out_valid_r, out_valid_nxt;
  sfpr_pkg::out_t                 out_r, out_nxt;

  logic                           fram_we, lram_we;
  logic [FW-1:0]                  fram_wa, fram_ra, lram_wa, lram_ra;
  logic [EW-1:0]                  fram_wd, lram_wd, fram_rd, lram_rd;

  logic [63:0]                    ash;
  logic [PAGE_BITS-1:0]           page_in;
  logic [CW-1:0]                  tot_eff, lenf;
  logic [sfpr_pkg::CFG_DATA_W-1:0] pct_eff;
  logic [sfpr_pkg::MUL_W-1:0]     mulv;
  logic                           t_flag, p_flag;

  sfpr_ram #(.WIDTH(EW), .DEPTH(MAX_FRAMES)) u_fifo_ram (
    .clk(clk), .we(fram_we), .waddr(fram_wa), .wdata(fram_wd), .raddr(fram_ra), .rdata(fram_rd)
  );

  sfpr_ram #(.WIDTH(EW), .DEPTH(MAX_FRAMES)) u_lru_ram (
    .clk(clk), .we(lram_we), .waddr(lram_wa), .wdata(lram_wd), .raddr(lram_ra), .rdata(lram_rd)
  );

  assign ash     = {32'd0, in_data.address} >> PAGE_SHIFT;
  assign page_in = ash[PAGE_BITS-1:0];
  assign tot_eff = (tot_cfg_r == '0) ? CW'(1) :
                   (int'(tot_cfg_r) > MAX_FRAMES) ? CW'(MAX_FRAMES) : CW'(tot_cfg_r);
  assign pct_eff = (pct_cfg_r > sfpr_pkg::PCT_MAX) ? sfpr_pkg::PCT_MAX : pct_cfg_r;
  assign mulv    = sfpr_pkg::MUL_W'(prod_r) * sfpr_pkg::MUL_W'(sfpr_pkg::DIV_MUL);
  assign lenf    = tot_r - lenl_r;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r; mode_nxt = mode_r;
    tot_cfg_nxt = tot_cfg_r; pct_cfg_nxt = pct_cfg_r;
    page_nxt = page_r; wr_nxt = wr_r; prod_nxt = prod_r;
    tot_nxt = tot_r; lenl_nxt = lenl_r;
    fhead_nxt = fhead_r; fused_nxt = fused_r; lhead_nxt = lhead_r; lused_nxt = lused_r;
    reads_nxt = reads_r; writes_nxt = writes_r; acc_nxt = acc_r;
    cnt_nxt = cnt_r; cidx_nxt = cidx_r; cv_nxt = cv_r;
    hitd_nxt = hitd_r; pop_nxt = pop_r;
    pop_pg_nxt = pop_pg_r; pop_d_nxt = pop_d_r;
    kind_nxt = kind_r; dw_nxt = dw_r; evv_nxt = evv_r; evp_nxt = evp_r;
    out_valid_nxt = 1'b0; out_nxt = out_r;
    fram_we = 1'b0; fram_wa = fhead_r; fram_wd = '0; fram_ra = fhead_r;
    lram_we = 1'b0; lram_wa = lhead_r; lram_wd = '0; lram_ra = lhead_r;
    t_flag = 1'b0; p_flag = 1'b0;

    // result beat, built from registered totals
    out_nxt.access_kind   = kind_r;
    out_nxt.disk_read     = (kind_r == sfpr_pkg::KIND_FAULT);
    out_nxt.disk_write    = dw_r;
    out_nxt.evicted_valid = evv_r;
    out_nxt.evicted_page  = sfpr_pkg::EVP_W'(evp_r);
    out_nxt.read_count    = reads_r;
    out_nxt.write_count   = writes_r;
    out_nxt.access_count  = acc_r;

    unique case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          if (cfg_index == sfpr_pkg::REG_TOTAL_FRAMES || cfg_index == sfpr_pkg::REG_LRU_PERCENT) begin
            if (cfg_index == sfpr_pkg::REG_TOTAL_FRAMES) begin
              tot_cfg_nxt = cfg_data;
            end else begin
              pct_cfg_nxt = cfg_data;
            end
            fhead_nxt = '0; fused_nxt = '0; lhead_nxt = '0; lused_nxt = '0;
          end
        end
        if (start) begin
          page_nxt = page_in; wr_nxt = in_data.is_write;
          acc_nxt = acc_r + 32'd1;
          kind_nxt = sfpr_pkg::KIND_HIT; dw_nxt = 1'b0; evv_nxt = 1'b0; evp_nxt = '0;
          state_nxt = S_PROD;
        end
      end
      S_PROD: begin
        tot_nxt   = tot_eff;
        prod_nxt  = sfpr_pkg::PROD_W'(tot_eff) * sfpr_pkg::PROD_W'(pct_eff);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        lenl_nxt  = CW'(mulv[sfpr_pkg::MUL_W-1:sfpr_pkg::DIV_SHIFT]);
        cnt_nxt   = '0; cv_nxt = 1'b0;
        state_nxt = S_FSRCH;
      end
      S_FSRCH: begin
        if (lenf == '0) begin
          state_nxt = S_LSRCH;
        end else if (cv_r && fram_rd[EW-1:1] == page_r) begin
          fram_we = 1'b1;
          fram_wa = phys(fhead_r, cidx_r);
          fram_wd = {page_r, fram_rd[0] | wr_r};
          cv_nxt = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (cnt_r < fused_r) begin
          fram_ra = phys(fhead_r, cnt_r);
          cv_nxt = 1'b1; cidx_nxt = cnt_r; cnt_nxt = cnt_r + CW'(1);
        end else begin
          cv_nxt = 1'b0; cnt_nxt = '0;
          if (lenl_r == '0) begin
            mode_nxt = M_FMISS; kind_nxt = sfpr_pkg::KIND_FAULT;
            reads_nxt = reads_r + 32'd1;
            p_flag = (fused_r >= tot_r) && (fused_r != '0);
            pop_nxt = p_flag;
            state_nxt = p_flag ? S_POP0 : S_FIN;
          end else begin
            state_nxt = S_LSRCH;
          end
        end
      end
      S_LSRCH: begin
        if (cv_r && lram_rd[EW-1:1] == page_r) begin
          pos_hit: begin
            hitd_nxt = lram_rd[0] | wr_r;
            cv_nxt = 1'b0;
            if (lenf == '0) begin
              mode_nxt = M_LHIT;
            end else begin
              mode_nxt = M_SOFT; kind_nxt = sfpr_pkg::KIND_SOFT;
              p_flag = (fused_r != '0);
            end
            pop_nxt = p_flag;
            if (cidx_r != '0) begin
              cnt_nxt = cidx_r;
              state_nxt = S_SHIFT;
            end else begin
              state_nxt = p_flag ? S_POP0 : S_FIN;
            end
          end
        end else if (cnt_r < lused_r) begin
          lram_ra = phys(lhead_r, cnt_r);
          cv_nxt = 1'b1; cidx_nxt = cnt_r; cnt_nxt = cnt_r + CW'(1);
        end else begin
          cv_nxt = 1'b0;
          kind_nxt = sfpr_pkg::KIND_FAULT;
          reads_nxt = reads_r + 32'd1;
          if (lenf == '0) begin
            mode_nxt = M_LMISS;
            t_flag = (lused_r >= tot_r);
          end else begin
            mode_nxt = M_MMISS;
            p_flag = (fused_r >= lenf);
            t_flag = p_flag && (lused_r >= lenl_r) && (lused_r != '0);
          end
          pop_nxt = p_flag;
          state_nxt = t_flag ? S_TAIL0 : (p_flag ? S_POP0 : S_FIN);
        end
      end
      S_SHIFT: begin
        if (cv_r) begin
          lram_we = 1'b1;
          lram_wa = phys(lhead_r, cidx_r + CW'(1));
          lram_wd = lram_rd;
        end
        if (cnt_r != '0) begin
          lram_ra = phys(lhead_r, cnt_r - CW'(1));
          cv_nxt = 1'b1; cidx_nxt = cnt_r - CW'(1); cnt_nxt = cnt_r - CW'(1);
        end else begin
          cv_nxt = 1'b0;
          if (!cv_r) begin
            state_nxt = pop_r ? S_POP0 : S_FIN;
          end
        end
      end
      S_TAIL0: begin
        lram_ra = phys(lhead_r, lused_r - CW'(1));
        state_nxt = S_TAIL1;
      end
      S_TAIL1: begin
        evv_nxt = 1'b1; evp_nxt = lram_rd[EW-1:1]; dw_nxt = lram_rd[0];
        if (lram_rd[0]) begin
          writes_nxt = writes_r + 32'd1;
        end
        lused_nxt = lused_r - CW'(1);
        state_nxt = pop_r ? S_POP0 : S_FIN;
      end
      S_POP0: begin
        fram_ra = fhead_r;
        state_nxt = S_POP1;
      end
      S_POP1: begin
        pop_pg_nxt = fram_rd[EW-1:1]; pop_d_nxt = fram_rd[0];
        fhead_nxt = inc_slot(fhead_r);
        fused_nxt = fused_r - CW'(1);
        if (mode_r == M_FMISS) begin
          evv_nxt = 1'b1; evp_nxt = fram_rd[EW-1:1]; dw_nxt = fram_rd[0];
          if (fram_rd[0]) begin
            writes_nxt = writes_r + 32'd1;
          end
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        case (mode_r)
          M_LHIT: begin
            lram_we = 1'b1; lram_wa = lhead_r; lram_wd = {page_r, hitd_r};
          end
          M_SOFT: begin
            if (pop_r) begin
              lram_we = 1'b1; lram_wa = lhead_r; lram_wd = {pop_pg_r, pop_d_r};
            end else begin
              lhead_nxt = inc_slot(lhead_r); lused_nxt = lused_r - CW'(1);
            end
            fram_we = 1'b1; fram_wa = phys(fhead_r, fused_r); fram_wd = {page_r, hitd_r};
            fused_nxt = fused_r + CW'(1);
          end
          M_LMISS: begin
            lram_we = 1'b1; lram_wa = dec_slot(lhead_r); lram_wd = {page_r, wr_r};
            lhead_nxt = dec_slot(lhead_r); lused_nxt = lused_r + CW'(1);
          end
          M_FMISS: begin
            fram_we = 1'b1; fram_wa = phys(fhead_r, fused_r); fram_wd = {page_r, wr_r};
            fused_nxt = fused_r + CW'(1);
          end
          default: begin
            if (pop_r) begin
              lram_we = 1'b1; lram_wa = dec_slot(lhead_r); lram_wd = {pop_pg_r, pop_d_r};
              lhead_nxt = dec_slot(lhead_r); lused_nxt = lused_r + CW'(1);
            end
            fram_we = 1'b1; fram_wa = phys(fhead_r, fused_r); fram_wd = {page_r, wr_r};
            fused_nxt = fused_r + CW'(1);
          end
        endcase
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tot_cfg_r <= sfpr_pkg::TOTAL_RESET; pct_cfg_r <= sfpr_pkg::PCT_RESET;
      fhead_r <= '0; fused_r <= '0; lhead_r <= '0; lused_r <= '0;
      reads_r <= '0; writes_r <= '0; acc_r <= '0;
      cv_r <= 1'b0; out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tot_cfg_r <= tot_cfg_nxt; pct_cfg_r <= pct_cfg_nxt;
      fhead_r <= fhead_nxt; fused_r <= fused_nxt; lhead_r <= lhead_nxt; lused_r <= lused_nxt;
      reads_r <= reads_nxt; writes_r <= writes_nxt; acc_r <= acc_nxt;
      cv_r <= cv_nxt; out_valid_r <= out_valid_nxt;
    end
    mode_r <= mode_nxt; page_r <= page_nxt; wr_r <= wr_nxt; prod_r <= prod_nxt;
    tot_r <= tot_nxt; lenl_r <= lenl_nxt; cnt_r <= cnt_nxt; cidx_r <= cidx_nxt;
    hitd_r <= hitd_nxt; pop_r <= pop_nxt;
    pop_pg_r <= pop_pg_nxt; pop_d_r <= pop_d_nxt;
    kind_r <= kind_nxt; dw_r <= dw_nxt; evv_r <= evv_nxt; evp_r <= evp_nxt;
    out_r <= out_nxt;
  end

`include "segmented_fifo_page_replacer_assert.svh"

  `SFPR_ASSERT_NOW(a_frames_bound, 1'b1, (int'(fused_r) + int'(lused_r) <= MAX_FRAMES), "frame count overflow")
  `SFPR_ASSERT_NOW(a_evp_zero, out_valid_r && !out_r.evicted_valid, out_r.evicted_page == '0, "stale evicted page")
  `SFPR_ASSERT_NOW(a_read_flag, out_valid_r, out_r.disk_read == (out_r.access_kind == sfpr_pkg::KIND_FAULT), "read flag mismatch")
  `SFPR_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted beat not taken")
  `SFPR_ASSERT_NOW(a_tail_pop, state_r == S_TAIL1 && mode_r == M_MMISS, pop_r, "lru evict without spill")

endmodule

// File: dv/segmented_fifo_page_replacer_test.sv
// testbench for the segmented fifo page replacer: random and directed accesses checked against a predictor
`timescale 1ns / 100ps

module segmented_fifo_page_replacer_test;

  localparam int FRAMES = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  sfpr_pkg::in_t in_data;
  logic out_valid;
  sfpr_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [sfpr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sfpr_pkg::CFG_DATA_W-1:0] cfg_data;

  segmented_fifo_page_replacer dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [6:0] frames_reg, pct_reg;
  logic [19:0] fq_page [FRAMES];
  logic fq_dirty [FRAMES];
  int fq_head, fq_used;
  logic [19:0] lr_page [FRAMES];
  logic lr_dirty [FRAMES];
  int lr_used;
  logic [31:0] reads_n, writes_n, accesses_n;

  sfpr_pkg::in_t access_queue[$];
  sfpr_pkg::out_t expected_q[$];
  int errors;
  int accepted_accesses;
  int faults_seen, softs_seen, evicts_seen;
  int watchdog;
  bit quiet_phase;
  int send_gap;
  bit cfg_pending;
  logic [sfpr_pkg::CFG_IDX_W-1:0] cfg_pend_idx;
  logic [sfpr_pkg::CFG_DATA_W-1:0] cfg_pend_val;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flush_segments();
    fq_head = 0;
    fq_used = 0;
    lr_used = 0;
  endtask

  task automatic add_access(input sfpr_pkg::in_t a);
    access_queue.insert(access_queue.size(), a);
  endtask

  function automatic int fq_slot(int i);
    return (fq_head + i) % FRAMES;
  endfunction

  task automatic fq_pop(output logic [19:0] pg, output logic dt);
    pg = fq_page[fq_head];
    dt = fq_dirty[fq_head];
    fq_head = (fq_head + 1) % FRAMES;
    fq_used--;
  endtask

  task automatic fq_push(input logic [19:0] pg, input logic dt);
    int s;
    if (fq_used < FRAMES) begin
      s = fq_slot(fq_used);
      fq_page[s] = pg;
      fq_dirty[s] = dt;
      fq_used++;
    end
  endtask

  task automatic lr_remove(input int pos);
    for (int i = pos; i < lr_used - 1; i++) begin
      lr_page[i] = lr_page[i + 1];
      lr_dirty[i] = lr_dirty[i + 1];
    end
    lr_used--;
  endtask

  task automatic lr_push_front(input logic [19:0] pg, input logic dt);
    if (lr_used >= FRAMES) lr_used = FRAMES - 1;
    for (int i = lr_used; i > 0; i--) begin
      lr_page[i] = lr_page[i - 1];
      lr_dirty[i] = lr_dirty[i - 1];
    end
    lr_page[0] = pg;
    lr_dirty[0] = dt;
    lr_used++;
  endtask

  function automatic int lr_find(input logic [19:0] pg);
    for (int i = 0; i < lr_used; i++) if (lr_page[i] == pg) return i;
    return -1;
  endfunction

  function automatic int fq_find(input logic [19:0] pg);
    for (int i = 0; i < fq_used; i++) if (fq_page[fq_slot(i)] == pg) return fq_slot(i);
    return -1;
  endfunction

  task automatic replace_page(input sfpr_pkg::in_t acc, output sfpr_pkg::out_t res);
    logic [19:0] pg, op;
    logic w, od;
    int tot, pct, n_lru, n_fifo, pos;
    pg = acc.address[31:12];
    w = acc.is_write;
    tot = frames_reg;
    pct = pct_reg;
    if (tot == 0) tot = 1;
    if (tot > FRAMES) tot = FRAMES;
    if (pct > 100) pct = 100;
    n_lru = tot * pct / 100;
    n_fifo = tot - n_lru;
    res = '0;
    res.access_kind = sfpr_pkg::KIND_HIT;
    accesses_n++;
    if (n_fifo == 0) begin
      pos = lr_find(pg);
      if (pos >= 0) begin
        od = lr_dirty[pos] | w;
        lr_remove(pos);
        lr_push_front(pg, od);
      end else begin
        res.access_kind = sfpr_pkg::KIND_FAULT;
        res.disk_read = 1'b1;
        reads_n++;
        if (lr_used >= tot) begin
          res.evicted_valid = 1'b1;
          res.evicted_page = lr_page[lr_used - 1];
          if (lr_dirty[lr_used - 1]) begin
            res.disk_write = 1'b1;
            writes_n++;
          end
          lr_used--;
        end
        lr_push_front(pg, w);
      end
    end else if ((pos = fq_find(pg)) >= 0) begin
      fq_dirty[pos] = fq_dirty[pos] | w;
    end else if (n_lru == 0) begin
      res.access_kind = sfpr_pkg::KIND_FAULT;
      res.disk_read = 1'b1;
      reads_n++;
      if (fq_used >= tot && fq_used > 0) begin
        fq_pop(op, od);
        res.evicted_valid = 1'b1;
        res.evicted_page = op;
        if (od) begin
          res.disk_write = 1'b1;
          writes_n++;
        end
      end
      fq_push(pg, w);
    end else if ((pos = lr_find(pg)) >= 0) begin
      w = lr_dirty[pos] | w;
      res.access_kind = sfpr_pkg::KIND_SOFT;
      lr_remove(pos);
      if (fq_used > 0) begin
        fq_pop(op, od);
        lr_push_front(op, od);
      end
      fq_push(pg, w);
    end else begin
      res.access_kind = sfpr_pkg::KIND_FAULT;
      res.disk_read = 1'b1;
      reads_n++;
      if (fq_used >= n_fifo) begin
        if (lr_used >= n_lru && lr_used > 0) begin
          res.evicted_valid = 1'b1;
          res.evicted_page = lr_page[lr_used - 1];
          if (lr_dirty[lr_used - 1]) begin
            res.disk_write = 1'b1;
            writes_n++;
          end
          lr_used--;
        end
        fq_pop(op, od);
        lr_push_front(op, od);
      end
      fq_push(pg, w);
    end
    res.read_count = reads_n;
    res.write_count = writes_n;
    res.access_count = accesses_n;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
      send_gap <= 0;
    end else if (start && !busy) begin
      if (access_queue.size() > 0 && !quiet_phase && $urandom_range(0, 5) == 0) begin
        start <= 1'b0;
        send_gap <= $urandom_range(1, 9);
      end else if (access_queue.size() > 0) begin
        in_data <= access_queue[0];
        access_queue.delete(0);
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (access_queue.size() > 0) begin
        start <= 1'b1;
        in_data <= access_queue[0];
        access_queue.delete(0);
      end
    end
  end

  // predict on each accepted beat
  always @(posedge clk) begin
    sfpr_pkg::out_t res;
    if (rst_n && start && !busy) begin
      replace_page(in_data, res);
      expected_q.insert(expected_q.size(), res);
      accepted_accesses++;
    end
  end

  // monitor
  always @(posedge clk) begin
    sfpr_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 32'd0, 32'd0);
      end else begin
        want = expected_q[0];
        expected_q.delete(0);
        if (out_data.access_kind != want.access_kind)
          report_mismatch("access_kind", 32'(out_data.access_kind), 32'(want.access_kind));
        if (out_data.disk_read != want.disk_read)
          report_mismatch("disk_read", 32'(out_data.disk_read), 32'(want.disk_read));
        if (out_data.disk_write != want.disk_write)
          report_mismatch("disk_write", 32'(out_data.disk_write), 32'(want.disk_write));
        if (out_data.evicted_valid != want.evicted_valid)
          report_mismatch("evicted_valid", 32'(out_data.evicted_valid),
                          32'(want.evicted_valid));
        if (out_data.evicted_page != want.evicted_page)
          report_mismatch("evicted_page", 32'(out_data.evicted_page),
                          32'(want.evicted_page));
        if (out_data.read_count != want.read_count)
          report_mismatch("read_count", out_data.read_count, want.read_count);
        if (out_data.write_count != want.write_count)
          report_mismatch("write_count", out_data.write_count, want.write_count);
        if (out_data.access_count != want.access_count)
          report_mismatch("access_count", out_data.access_count, want.access_count);
        if (want.access_kind == sfpr_pkg::KIND_FAULT) faults_seen++;
        if (want.access_kind == sfpr_pkg::KIND_SOFT) softs_seen++;
        if (want.evicted_valid) evicts_seen++;
      end
    end
  end

  // config channel
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
      cfg_index <= sfpr_pkg::REG_TOTAL_FRAMES;
      cfg_data <= '0;
    end else if (cfg_valid && cfg_ready) begin
      cfg_valid <= 1'b0;
      if (cfg_index == sfpr_pkg::REG_TOTAL_FRAMES) frames_reg = cfg_data;
      else pct_reg = cfg_data;
      flush_segments();
      cfg_pending = 1'b0;
    end else if (cfg_pending && !cfg_valid) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_pend_idx;
      cfg_data <= cfg_pend_val;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      watchdog <= 0;
    end else begin
      watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic drain();
    while (access_queue.size() > 0 || start || expected_q.size() > 0) @(posedge clk);
    repeat (2 * FRAMES + 20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sfpr_pkg::CFG_IDX_W-1:0] idx, input logic [6:0] val);
    drain();
    cfg_pend_idx = idx;
    cfg_pend_val = val;
    cfg_pending = 1'b1;
    while (cfg_pending) @(posedge clk);
  endtask

  function automatic sfpr_pkg::in_t mk_access(input logic [19:0] pg, input logic w);
    sfpr_pkg::in_t a;
    a.address = {pg, 12'(($urandom))};
    a.is_write = w;
    return a;
  endfunction

  // working set a bit larger than the frame count makes hits, soft faults and evictions
  task automatic queue_random(input int n, input int span);
    sfpr_pkg::in_t a;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        a.address = $urandom;
        a.is_write = 1'($urandom_range(0, 1));
      end else begin
        a = mk_access(20'($urandom_range(0, span)) ^ 20'hA5A50, 1'($urandom_range(0, 1)));
      end
      add_access(a);
    end
  endtask

  initial begin
    int settings[7][2];
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = sfpr_pkg::REG_TOTAL_FRAMES;
    cfg_data = '0;
    errors = 0;
    accepted_accesses = 0;
    faults_seen = 0;
    softs_seen = 0;
    evicts_seen = 0;
    quiet_phase = 1'b0;
    cfg_pending = 1'b0;
    frames_reg = sfpr_pkg::TOTAL_RESET;
    pct_reg = sfpr_pkg::PCT_RESET;
    reads_n = '0;
    writes_n = '0;
    accesses_n = '0;
    flush_segments();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, reset split
    add_access(mk_access(20'h00000, 1'b0));
    add_access(mk_access(20'hFFFFF, 1'b1));
    add_access(sfpr_pkg::in_t'({32'hFFFFFFFF, 1'b1}));
    add_access(sfpr_pkg::in_t'({32'h00000000, 1'b0}));
    add_access(sfpr_pkg::in_t'({32'h55555555, 1'b1}));
    add_access(sfpr_pkg::in_t'({32'hAAAAAAAA, 1'b0}));
    drain();
    // small split: 4 frames, 50 percent, force soft faults and dirty write-back
    write_reg(sfpr_pkg::REG_TOTAL_FRAMES, 7'd4);
    write_reg(sfpr_pkg::REG_LRU_PERCENT, 7'd50);
    for (int i = 0; i < 6; i++) add_access(mk_access(20'(i), 1'b1));
    add_access(mk_access(20'd2, 1'b0));
    add_access(mk_access(20'd3, 1'b1));
    add_access(mk_access(20'd9, 1'b0));
    add_access(mk_access(20'd10, 1'b0));
    // zero frames and pure lru above 100 percent
    write_reg(sfpr_pkg::REG_TOTAL_FRAMES, 7'd0);
    write_reg(sfpr_pkg::REG_LRU_PERCENT, 7'd127);
    for (int i = 0; i < 4; i++) add_access(mk_access(20'(i % 2 + i / 3), 1'(i)));

    settings = '{'{4, 50}, '{1, 0}, '{127, 25}, '{8, 0}, '{10, 100}, '{16, 30}, '{64, 25}};
    for (int s = 0; s < 7; s++) begin
      write_reg(sfpr_pkg::REG_TOTAL_FRAMES, 7'(settings[s][0]));
      write_reg(sfpr_pkg::REG_LRU_PERCENT, 7'(settings[s][1]));
      if (s == 6) begin
        drain();
        quiet_phase = 1'b1;
      end
      queue_random(110, settings[s][0] > 64 ? 80 : settings[s][0] + settings[s][0] / 2 + 2);
    end
    drain();

    $display("covered %0d accesses over several frame splits", accepted_accesses);
    $display("faults %0d, soft faults %0d, evictions %0d", faults_seen, softs_seen, evicts_seen);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
